// ----- design/skf_pkg.sv -----
// skf_pkg: widths, fixed-point constants, register codes and shared types
// for the scalar kalman sample filter; no dependencies
`default_nettype none

package skf_pkg;

  // fixed-point format of covariance, noise terms and gain
  localparam int FRAC_BITS = 24;
  localparam int SAMPLE_W  = 16;
  localparam int FX_W      = 32;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int DEN_W     = FX_W + 1;
  localparam int REM_W     = FX_W + 2;
  localparam int PROD_W    = 2 * FX_W;
  localparam int DCNT_W    = $clog2(GAIN_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  // reset values, rounded to nearest and saturated to the 32-bit range
  localparam longint unsigned ONE_L    = 64'd1 << FRAC_BITS;
  localparam longint unsigned MAX_L    = 64'hFFFF_FFFF;
  localparam longint unsigned Q_RST_L  = (25 * ONE_L + 500) / 1000;
  localparam longint unsigned R_RST_L  = (ONE_L + 500) / 1000;
  localparam longint unsigned P_RST_L  = 10 * ONE_L;
  localparam logic [FX_W-1:0] Q_RST = FX_W'((Q_RST_L > MAX_L) ? MAX_L : Q_RST_L);
  localparam logic [FX_W-1:0] R_RST = FX_W'((R_RST_L > MAX_L) ? MAX_L : R_RST_L);
  localparam logic [FX_W-1:0] P_RST = FX_W'((P_RST_L > MAX_L) ? MAX_L : P_RST_L);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

  // divider request from the sequencer
  typedef struct packed {
    logic             start;
    logic [FX_W-1:0]  num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // multiplier request from the sequencer
  typedef struct packed {
    logic            start;
    logic [FX_W-1:0] op_a;
    logic [FX_W-1:0] op_b;
  } mul_req_t;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SAT  = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_MUL1 = 7'b0010000,
    ST_MUL2 = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- design/skf_if.sv -----
// skf_if: valid/ready channel interfaces for samples and filtered results
// depends on skf_pkg for the payload widths
`default_nettype none

interface skf_in_if;
  logic                         valid;
  logic                         ready;
  logic [skf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface skf_out_if;
  logic                         valid;
  logic                         ready;
  logic [skf_pkg::SAMPLE_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ----- design/scalar_kalman_sample_filter_top.sv -----
// scalar_kalman_sample_filter_top: sequencer, state and registers of the filter
// depends on skf_pkg, skf_if, skf_div and skf_mul
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    sample   [15:0]
//   out_chan  out  valid/ready    filtered [15:0]
//   cfg_*     in   cfg_we         cfg_idx [0], cfg_wdata [31:0]
//
// an item passes through the saturate, load, divide, two multiply and done states
// from accept to result; the bit-per-cycle divider forms the gain
// in_chan.ready is high only while the sequencer is idle; a result waits in the
// output register while the next sample is accepted and worked on
// the final step stalls until the output register is free
// synchronous active-low reset restores estimate, covariance and noise terms
`default_nettype none

module scalar_kalman_sample_filter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  skf_in_if.sink                             in_chan,
  skf_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [skf_pkg::FX_W-1:0]      cfg_wdata
);

  localparam int F   = skf_pkg::FRAC_BITS;
  localparam int SW  = skf_pkg::SAMPLE_W;
  localparam int FW  = skf_pkg::FX_W;
  localparam int GW  = skf_pkg::GAIN_W;
  localparam int PW  = skf_pkg::PROD_W;

  skf_pkg::state_t             state_r, state_nxt;
  logic [FW-1:0]               q_r;
  logic [FW-1:0]               r_r;
  logic [SW-1:0]               est_r;
  logic [FW-1:0]               cov_r;
  logic [SW-1:0]               sample_r;
  logic [FW-1:0]               p1_r;
  logic                        den_zero_r;
  logic                        neg_r;
  logic [SW-1:0]               mag_r;
  logic [GW-1:0]               gain_r;
  logic [SW-1:0]               step_r;
  logic                        out_valid_r;
  logic [SW-1:0]               out_data_r;

  logic [FW:0]                 p_sum;
  logic [skf_pkg::DEN_W-1:0]   den;
  skf_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [GW-1:0]               div_quo;
  skf_pkg::mul_req_t           mul_req;
  logic [PW-1:0]               mul_prod;
  logic [PW-1:0]               prod_round;
  logic                        in_fire;
  logic                        out_free;
  logic [SW-1:0]               est_new;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // saturating p + q and the gain denominator
  assign p_sum = {1'b0, cov_r} + {1'b0, q_r};
  assign den   = {1'b0, p1_r} + {1'b0, r_r};

  // divider and multiplier requests
  always_comb begin
    div_req.start = (state_r == skf_pkg::ST_LOAD);
    div_req.num   = p1_r;
    div_req.den   = den;

    mul_req.start = (state_r == skf_pkg::ST_MUL1) || (state_r == skf_pkg::ST_MUL2);
    if (state_r == skf_pkg::ST_MUL1) begin
      mul_req.op_a = FW'(gain_r);
      mul_req.op_b = FW'(mag_r);
    end else begin
      mul_req.op_a = FW'(skf_pkg::GAIN_ONE - gain_r);
      mul_req.op_b = p1_r;
    end
  end

  skf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  skf_mul u_mul (
    .clk     (clk),
    .req     (mul_req),
    .product (mul_prod)
  );

  // step rounded toward minus infinity when moving down
  assign prod_round = mul_prod + PW'((64'd1 << F) - 64'd1);
  assign est_new    = neg_r ? (est_r - step_r) : (est_r + step_r);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skf_pkg::ST_IDLE: if (in_fire) state_nxt = skf_pkg::ST_SAT;
      skf_pkg::ST_SAT:  state_nxt = skf_pkg::ST_LOAD;
      skf_pkg::ST_LOAD: state_nxt = skf_pkg::ST_DIV;
      skf_pkg::ST_DIV:  if (div_done) state_nxt = skf_pkg::ST_MUL1;
      skf_pkg::ST_MUL1: state_nxt = skf_pkg::ST_MUL2;
      skf_pkg::ST_MUL2: state_nxt = skf_pkg::ST_DONE;
      skf_pkg::ST_DONE: if (out_free) state_nxt = skf_pkg::ST_IDLE;
      default:          state_nxt = skf_pkg::ST_IDLE;
    endcase
  end

  // control state, filter state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::ST_IDLE;
      q_r         <= skf_pkg::Q_RST;
      r_r         <= skf_pkg::R_RST;
      est_r       <= '0;
      cov_r       <= skf_pkg::P_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          skf_pkg::REG_PROCESS_NOISE:     q_r <= cfg_wdata;
          skf_pkg::REG_MEASUREMENT_NOISE: r_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == skf_pkg::ST_DONE) && out_free) begin
        est_r       <= est_new;
        cov_r       <= mul_prod[F+FW-1:F];
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-transaction datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_chan.sample;
    end
    if (state_r == skf_pkg::ST_SAT) begin
      p1_r <= p_sum[FW] ? '1 : p_sum[FW-1:0];
      if (sample_r >= est_r) begin
        neg_r <= 1'b0;
        mag_r <= sample_r - est_r;
      end else begin
        neg_r <= 1'b1;
        mag_r <= est_r - sample_r;
      end
    end
    if (state_r == skf_pkg::ST_LOAD) begin
      den_zero_r <= (den == '0);
    end
    if ((state_r == skf_pkg::ST_DIV) && div_done) begin
      gain_r <= den_zero_r ? skf_pkg::GAIN_ONE : div_quo;
    end
    if (state_r == skf_pkg::ST_MUL2) begin
      step_r <= neg_r ? prod_round[F+SW-1:F] : mul_prod[F+SW-1:F];
    end
    if ((state_r == skf_pkg::ST_DONE) && out_free) begin
      out_data_r <= est_new;
    end
  end

  assign in_chan.ready     = (state_r == skf_pkg::ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.filtered = out_data_r;

endmodule

`default_nettype wire

// ----- design/skf_div.sv -----
// skf_div: restoring divider, one quotient bit per cycle, GAIN_W bits
// computes floor((num << FRAC_BITS) / den) for num <= den; depends on skf_pkg
`default_nettype none

module skf_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire skf_pkg::div_req_t          req,
  output logic                            done,
  output logic [skf_pkg::GAIN_W-1:0]      quotient
);

  logic                         busy_r;
  logic                         done_r;
  logic [skf_pkg::DCNT_W-1:0]   cnt_r;
  logic [skf_pkg::REM_W-1:0]    rem_r;
  logic [skf_pkg::DEN_W-1:0]    den_r;
  logic [skf_pkg::GAIN_W-1:0]   quo_r;
  logic                         rem_ge;
  logic [skf_pkg::REM_W-1:0]    rem_sub;

  // shared compare and subtract
  always_comb begin
    rem_ge  = rem_r >= {1'b0, den_r};
    rem_sub = rem_ge ? (rem_r - {1'b0, den_r}) : rem_r;
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // done pulses for one cycle as the last quotient bit is registered
      done_r <= busy_r && !req.start && (cnt_r == '0);
      if (req.start) begin
        rem_r  <= {2'b00, req.num};
        den_r  <= req.den;
        quo_r  <= '0;
        cnt_r  <= skf_pkg::DCNT_W'(skf_pkg::GAIN_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[skf_pkg::GAIN_W-2:0], rem_ge};
        rem_r <= {rem_sub[skf_pkg::REM_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- design/skf_mul.sv -----
// skf_mul: shared 32x32 multiplier with registered product
// used for the estimate step and the covariance update; depends on skf_pkg
`default_nettype none

module skf_mul (
  input  wire logic                     clk,
  input  wire skf_pkg::mul_req_t        req,
  output logic [skf_pkg::PROD_W-1:0]    product
);

  logic [skf_pkg::PROD_W-1:0] prod_r;

  // product holds until the next request
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= skf_pkg::PROD_W'(req.op_a) * skf_pkg::PROD_W'(req.op_b);
    end
  end

  assign product = prod_r;

endmodule

`default_nettype wire
